@@ sv/voice_utterance_endpointer_defines.svh @@
// Assertion macros shared by the endpointer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef VOICE_UTTERANCE_ENDPOINTER_DEFINES_SVH
`define VOICE_UTTERANCE_ENDPOINTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VUE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("endpointer check failed");

// Next-cycle implication, checked out of reset
`define VUE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("endpointer check failed");

`endif

@@ sv/vue_pkg.sv @@
package vue_pkg;

    // Chunk bytes per millisecond of audio
    localparam int unsigned BYTES_PER_MS = 32;

    localparam int unsigned MS_W    = 16;
    localparam int unsigned BYTES_W = 19;
    localparam int unsigned CHUNK_W = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 19;

    // Modes
    localparam logic [1:0] MODE_LISTEN = 2'd0;
    localparam logic [1:0] MODE_REC    = 2'd1;
    localparam logic [1:0] MODE_READY  = 2'd2;
    localparam logic [1:0] MODE_LENT   = 2'd3;

    // Commands
    localparam logic [1:0] CMD_CHUNK  = 2'd0;
    localparam logic [1:0] CMD_FOLLOW = 2'd1;
    localparam logic [1:0] CMD_PAUSE  = 2'd2;
    localparam logic [1:0] CMD_RESUME = 2'd3;

    // End reasons
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_SILENCE = 2'd1;
    localparam logic [1:0] REASON_CAP     = 2'd2;
    localparam logic [1:0] REASON_NOTHING = 2'd3;

    // Face requests
    localparam logic [1:0] FACE_NONE    = 2'd0;
    localparam logic [1:0] FACE_REC     = 2'd1;
    localparam logic [1:0] FACE_STANDBY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_SPEECH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES  = 3'd4;

    // Register reset values
    localparam logic [MS_W-1:0]    RST_SILENCE_LIMIT = 16'd900;
    localparam logic [MS_W-1:0]    RST_MAX_RECORD    = 16'd8000;
    localparam logic [MS_W-1:0]    RST_MIN_SPEECH    = 16'd400;
    localparam logic [MS_W-1:0]    RST_WAIT_SPEECH   = 16'd5000;
    localparam logic [BYTES_W-1:0] RST_BUFFER_BYTES  = 19'd320000;

    typedef struct packed {
        logic [MS_W-1:0]    silence_limit_ms;
        logic [MS_W-1:0]    max_record_ms;
        logic [MS_W-1:0]    min_speech_ms;
        logic [MS_W-1:0]    wait_for_speech_ms;
        logic [BYTES_W-1:0] buffer_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               wake_detected;
        logic               speech_present;
        logic [CHUNK_W-1:0] chunk_bytes;
        logic               playback_busy;
    } item_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [BYTES_W-1:0] captured_bytes;
        logic [MS_W-1:0]    recorded_ms;
        logic [1:0]         end_reason;
        logic [1:0]         face_request;
        logic               wake_event;
    } result_t;

endpackage

@@ sv/vue_if.sv @@
interface vue_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic                          wake_detected;
    logic                          speech_present;
    logic [vue_pkg::CHUNK_W-1:0]   chunk_bytes;
    logic                          playback_busy;

    modport source (output valid, cmd, wake_detected, speech_present, chunk_bytes,
                    playback_busy, input ready);
    modport sink   (input valid, cmd, wake_detected, speech_present, chunk_bytes,
                    playback_busy, output ready);
endinterface

interface vue_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [vue_pkg::BYTES_W-1:0]   captured_bytes;
    logic [vue_pkg::MS_W-1:0]      recorded_ms;
    logic [1:0]                    end_reason;
    logic [1:0]                    face_request;
    logic                          wake_event;

    modport source (output valid, mode, captured_bytes, recorded_ms, end_reason,
                    face_request, wake_event, input ready);
    modport sink   (input valid, mode, captured_bytes, recorded_ms, end_reason,
                    face_request, wake_event, output ready);
endinterface

@@ sv/vue_cfg_regs.sv @@
module vue_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vue_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vue_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vue_pkg::cfg_t                      cfg
);

    vue_pkg::cfg_t cfg_reg;
    vue_pkg::cfg_t cfg_next;

    // Decode the write into the addressed field; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                vue_pkg::REG_SILENCE_LIMIT:
                    cfg_next.silence_limit_ms = cfg_data[vue_pkg::MS_W-1:0];
                vue_pkg::REG_MAX_RECORD:
                    cfg_next.max_record_ms = cfg_data[vue_pkg::MS_W-1:0];
                vue_pkg::REG_MIN_SPEECH:
                    cfg_next.min_speech_ms = cfg_data[vue_pkg::MS_W-1:0];
                vue_pkg::REG_WAIT_SPEECH:
                    cfg_next.wait_for_speech_ms = cfg_data[vue_pkg::MS_W-1:0];
                vue_pkg::REG_BUFFER_BYTES:
                    cfg_next.buffer_bytes = cfg_data[vue_pkg::BYTES_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_limit_ms   <= vue_pkg::RST_SILENCE_LIMIT;
            cfg_reg.max_record_ms      <= vue_pkg::RST_MAX_RECORD;
            cfg_reg.min_speech_ms      <= vue_pkg::RST_MIN_SPEECH;
            cfg_reg.wait_for_speech_ms <= vue_pkg::RST_WAIT_SPEECH;
            cfg_reg.buffer_bytes       <= vue_pkg::RST_BUFFER_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/vue_engine.sv @@
module vue_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  vue_pkg::item_t   item,
    input  vue_pkg::cfg_t    cfg,
    output vue_pkg::result_t result
);

    localparam int unsigned MS_W    = vue_pkg::MS_W;
    localparam int unsigned BYTES_W = vue_pkg::BYTES_W;
    localparam int unsigned CHUNK_W = vue_pkg::CHUNK_W;

    logic [1:0]         mode_reg, mode_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [MS_W-1:0]    elapsed_reg, elapsed_next;
    logic [MS_W-1:0]    silence_reg, silence_next;
    logic [MS_W-1:0]    speech_reg, speech_next;
    logic               susp_reg, susp_next;

    logic [CHUNK_W-1:0] chunk_ms;
    logic [BYTES_W:0]   byte_sum;
    logic [MS_W-1:0]    el_add, sp_add, si_add;
    logic               talked_done, capped, nothing_said;
    logic [1:0]         reason;
    logic [1:0]         face;
    logic               wake_ev;

    // Saturating 16-bit millisecond add
    function automatic logic [MS_W-1:0] sat_add(input logic [MS_W-1:0] a,
                                                input logic [CHUNK_W-1:0] b);
        logic [MS_W:0] s;
        s = {1'b0, a} + {{(MS_W + 1 - CHUNK_W){1'b0}}, b};
        return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
    endfunction

    // Per-chunk arithmetic on the current window
    assign chunk_ms = CHUNK_W'(item.chunk_bytes / vue_pkg::BYTES_PER_MS);
    assign byte_sum = {1'b0, bytes_reg} + {{(BYTES_W + 1 - CHUNK_W){1'b0}}, item.chunk_bytes};
    assign el_add   = sat_add(elapsed_reg, chunk_ms);
    assign sp_add   = sat_add(speech_reg, chunk_ms);
    assign si_add   = sat_add(silence_reg, chunk_ms);

    // Step the mode machine for one item
    always_comb
    begin
        mode_next    = mode_reg;
        bytes_next   = bytes_reg;
        elapsed_next = elapsed_reg;
        silence_next = silence_reg;
        speech_next  = speech_reg;
        susp_next    = susp_reg;
        reason       = vue_pkg::REASON_NONE;
        face         = vue_pkg::FACE_NONE;
        wake_ev      = 1'b0;
        talked_done  = 1'b0;
        capped       = 1'b0;
        nothing_said = 1'b0;

        unique case (item.cmd)
            vue_pkg::CMD_FOLLOW:
            begin
                bytes_next   = '0;
                elapsed_next = '0;
                silence_next = '0;
                speech_next  = '0;
                mode_next    = vue_pkg::MODE_REC;
            end
            vue_pkg::CMD_PAUSE:
            begin
                mode_next = vue_pkg::MODE_LENT;
            end
            vue_pkg::CMD_RESUME:
            begin
                bytes_next = '0;
                mode_next  = vue_pkg::MODE_LISTEN;
            end
            default:
            begin
                if (mode_reg == vue_pkg::MODE_READY || mode_reg == vue_pkg::MODE_LENT ||
                    item.playback_busy)
                begin
                    susp_next = 1'b1;
                end
                else
                begin
                    // Leave suspension; restore the recording face
                    if (susp_reg)
                    begin
                        susp_next = 1'b0;
                        if (mode_reg == vue_pkg::MODE_REC)
                            face = vue_pkg::FACE_REC;
                    end

                    if (mode_reg == vue_pkg::MODE_LISTEN)
                    begin
                        if (item.wake_detected)
                        begin
                            face         = vue_pkg::FACE_REC;
                            wake_ev      = 1'b1;
                            bytes_next   = '0;
                            elapsed_next = '0;
                            silence_next = '0;
                            speech_next  = '0;
                            mode_next    = vue_pkg::MODE_REC;
                        end
                    end
                    else
                    begin
                        // Accumulate bytes only while the chunk fits the buffer
                        if (byte_sum <= {1'b0, cfg.buffer_bytes})
                            bytes_next = byte_sum[BYTES_W-1:0];
                        elapsed_next = el_add;
                        if (item.speech_present)
                        begin
                            speech_next  = sp_add;
                            silence_next = '0;
                        end
                        else
                        begin
                            silence_next = si_add;
                        end

                        talked_done  = (silence_next >= cfg.silence_limit_ms) &&
                                       (speech_next >= cfg.min_speech_ms);
                        capped       = elapsed_next >= cfg.max_record_ms;
                        nothing_said = (elapsed_next >= cfg.wait_for_speech_ms) &&
                                       (speech_next < cfg.min_speech_ms);

                        if (nothing_said)
                        begin
                            reason     = vue_pkg::REASON_NOTHING;
                            face       = vue_pkg::FACE_STANDBY;
                            bytes_next = '0;
                            mode_next  = vue_pkg::MODE_LISTEN;
                        end
                        else if (talked_done || capped)
                        begin
                            reason    = capped ? vue_pkg::REASON_CAP : vue_pkg::REASON_SILENCE;
                            mode_next = vue_pkg::MODE_READY;
                        end
                    end
                end
            end
        endcase
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= vue_pkg::MODE_LISTEN;
            bytes_reg   <= '0;
            elapsed_reg <= '0;
            silence_reg <= '0;
            speech_reg  <= '0;
            susp_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            bytes_reg   <= bytes_next;
            elapsed_reg <= elapsed_next;
            silence_reg <= silence_next;
            speech_reg  <= speech_next;
            susp_reg    <= susp_next;
        end
    end

    // Build the result for this item
    always_comb
    begin
        result.mode           = mode_next;
        result.captured_bytes = (mode_next == vue_pkg::MODE_READY) ? bytes_next : '0;
        result.recorded_ms    = elapsed_next;
        result.end_reason     = reason;
        result.face_request   = face;
        result.wake_event     = wake_ev;
    end

endmodule

@@ sv/voice_utterance_endpointer.sv @@
// Voice utterance endpointer: one result per request, in request order.
// Each request passes through the input register, then the result register.
// Throughput: one request per cycle unless the result side stalls; the mode step
// is a single pass between the input register and the result register.
// Reset (rst_n, async, active low): mode listening, counters and suspend flag
// cleared, registers at their defaults, both pipeline stages empty.
`include "voice_utterance_endpointer_defines.svh"

module voice_utterance_endpointer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vue_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vue_pkg::CFG_DATA_W-1:0] cfg_data,
    vue_in_if.sink                         chunk,
    vue_out_if.source                      result
);

    vue_pkg::cfg_t    cfg;
    vue_pkg::item_t   item_reg, item_in;
    vue_pkg::result_t res_reg, res_comb;
    logic             item_valid_reg, item_valid_next;
    logic             res_valid_reg, res_valid_next;
    logic             accept, advance;

    vue_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vue_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    // Handshake: advance when the result slot is free or being drained
    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign chunk.ready  = !item_valid_reg || advance;
    assign accept       = chunk.valid && chunk.ready;

    always_comb
    begin
        item_in.cmd            = chunk.cmd;
        item_in.wake_detected  = chunk.wake_detected;
        item_in.speech_present = chunk.speech_present;
        item_in.chunk_bytes    = chunk.chunk_bytes;
        item_in.playback_busy  = chunk.playback_busy;
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    // Hold the request and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_comb;
    end

    assign result.valid          = res_valid_reg;
    assign result.mode           = res_reg.mode;
    assign result.captured_bytes = res_reg.captured_bytes;
    assign result.recorded_ms    = res_reg.recorded_ms;
    assign result.end_reason     = res_reg.end_reason;
    assign result.face_request   = res_reg.face_request;
    assign result.wake_event     = res_reg.wake_event;

    `VUE_ASSERT_IMP(a_bytes_only_ready, res_valid_reg && (res_reg.mode != vue_pkg::MODE_READY), res_reg.captured_bytes == '0)
    `VUE_ASSERT_IMP(a_wake_enters_rec, res_valid_reg && res_reg.wake_event, (res_reg.mode == vue_pkg::MODE_REC) && (res_reg.face_request == vue_pkg::FACE_REC))
    `VUE_ASSERT_IMP(a_nothing_to_listen, res_valid_reg && (res_reg.end_reason == vue_pkg::REASON_NOTHING), (res_reg.mode == vue_pkg::MODE_LISTEN) && (res_reg.face_request == vue_pkg::FACE_STANDBY))
    `VUE_ASSERT_NXT(a_stall_blocks_input, item_valid_reg && res_valid_reg && !result.ready, item_valid_reg && res_valid_reg)

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vue_pkg::*;

    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WORK_TARGET     = 1050;
    localparam int IDLE_PCT        = 24;
    localparam int SATURATE_CHUNKS = 540;

    typedef struct {
        bit      fixed;
        result_t value;
    } pinned_result_t;

    typedef struct {
        bit             is_cfg;
        cfg_t           limits;
        item_t          req;
        pinned_result_t pin;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vue_in_if  chunk_if ();
    vue_out_if result_if ();

    voice_utterance_endpointer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chunk     (chunk_if),
        .result    (result_if)
    );

    // Endpointer model state and its register copy
    logic [1:0]         ep_mode;
    logic [BYTES_W-1:0] ep_bytes;
    logic [MS_W-1:0]    ep_elapsed;
    logic [MS_W-1:0]    ep_silence;
    logic [MS_W-1:0]    ep_speech;
    bit                 ep_suspended;
    cfg_t               ep_limits;

    result_t        endpoint_reports[$];
    pinned_result_t pinned_results[$];
    plan_row_t      test_plan[$];

    int sent_count;
    int reports_seen;
    int worked_items;
    int mismatches;
    bit hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [MS_W-1:0] sat_ms(logic [MS_W-1:0] a, logic [MS_W-1:0] b);
        logic [MS_W:0] sum;
        sum = a + b;
        return sum[MS_W] ? '1 : sum[MS_W-1:0];
    endfunction

    function automatic void clear_window();
        ep_bytes   = '0;
        ep_elapsed = '0;
        ep_silence = '0;
        ep_speech  = '0;
    endfunction

    function automatic void store_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SILENCE_LIMIT: ep_limits.silence_limit_ms   = val[MS_W-1:0];
            REG_MAX_RECORD:    ep_limits.max_record_ms      = val[MS_W-1:0];
            REG_MIN_SPEECH:    ep_limits.min_speech_ms      = val[MS_W-1:0];
            REG_WAIT_SPEECH:   ep_limits.wait_for_speech_ms = val[MS_W-1:0];
            REG_BUFFER_BYTES:  ep_limits.buffer_bytes       = val[BYTES_W-1:0];
            default: ;
        endcase
    endfunction

    // Step the endpointer by one request; flag chunks that change nothing
    function automatic result_t advance_endpointer(input item_t req, output bit idle_chunk);
        result_t          rep;
        logic [MS_W-1:0]  ms;
        logic [BYTES_W:0] fill;
        bit               talked_done;
        bit               capped;
        bit               nothing_said;
        rep = '0;
        idle_chunk = 1'b0;
        ms = MS_W'(req.chunk_bytes / BYTES_PER_MS);
        case (req.cmd)
            CMD_FOLLOW:
            begin
                clear_window();
                ep_mode = MODE_REC;
            end
            CMD_PAUSE:
                ep_mode = MODE_LENT;
            CMD_RESUME:
            begin
                ep_bytes = '0;
                ep_mode  = MODE_LISTEN;
            end
            CMD_CHUNK:
            begin
                if (ep_mode == MODE_READY || ep_mode == MODE_LENT || req.playback_busy)
                    ep_suspended = 1'b1;
                else
                begin
                    idle_chunk = ep_mode == MODE_LISTEN && !req.wake_detected && !ep_suspended;
                    // first live chunk after a suspension restores the recording face
                    if (ep_suspended)
                    begin
                        ep_suspended = 1'b0;
                        if (ep_mode == MODE_REC)
                            rep.face_request = FACE_REC;
                    end
                    if (ep_mode == MODE_LISTEN)
                    begin
                        if (req.wake_detected)
                        begin
                            rep.face_request = FACE_REC;
                            rep.wake_event   = 1'b1;
                            clear_window();
                            ep_mode = MODE_REC;
                        end
                    end
                    else
                    begin
                        // drop the bytes once the buffer would overflow, keep the time
                        fill = {1'b0, ep_bytes} + req.chunk_bytes;
                        if (fill <= {1'b0, ep_limits.buffer_bytes})
                            ep_bytes = fill[BYTES_W-1:0];
                        ep_elapsed = sat_ms(ep_elapsed, ms);
                        if (req.speech_present)
                        begin
                            ep_speech  = sat_ms(ep_speech, ms);
                            ep_silence = '0;
                        end
                        else
                            ep_silence = sat_ms(ep_silence, ms);
                        talked_done = ep_silence >= ep_limits.silence_limit_ms &&
                                      ep_speech >= ep_limits.min_speech_ms;
                        capped = ep_elapsed >= ep_limits.max_record_ms;
                        nothing_said = ep_elapsed >= ep_limits.wait_for_speech_ms &&
                                       ep_speech < ep_limits.min_speech_ms;
                        if (nothing_said)
                        begin
                            rep.end_reason   = REASON_NOTHING;
                            rep.face_request = FACE_STANDBY;
                            ep_bytes = '0;
                            ep_mode  = MODE_LISTEN;
                        end
                        else if (talked_done || capped)
                        begin
                            rep.end_reason = capped ? REASON_CAP : REASON_SILENCE;
                            ep_mode = MODE_READY;
                        end
                    end
                end
            end
        endcase
        rep.mode           = ep_mode;
        rep.captured_bytes = (ep_mode == MODE_READY) ? ep_bytes : '0;
        rep.recorded_ms    = ep_elapsed;
        return rep;
    endfunction

    function automatic void plan_request(item_t req, bit fixed = 1'b0, result_t value = '0);
        plan_row_t row;
        row = '{is_cfg: 1'b0, limits: '0, req: req, pin: '{fixed, value}};
        test_plan.push_back(row);
    endfunction

    function automatic void plan_settings(cfg_t limits);
        plan_row_t row;
        row = '{is_cfg: 1'b1, limits: limits, req: '0, pin: '{1'b0, '0}};
        test_plan.push_back(row);
    endfunction

    function automatic logic [MS_W-1:0] pick_ms(int unsigned lo, int unsigned hi);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return MS_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic offer_request(item_t req, int gap_pct, bit fixed = 1'b0,
                                 result_t value = '0);
        pinned_results.push_back('{fixed, value});
        while ($urandom_range(99) < gap_pct)
        begin
            chunk_if.valid <= 1'b0;
            @(posedge clk);
        end
        chunk_if.valid          <= 1'b1;
        chunk_if.cmd            <= req.cmd;
        chunk_if.wake_detected  <= req.wake_detected;
        chunk_if.speech_present <= req.speech_present;
        chunk_if.chunk_bytes    <= req.chunk_bytes;
        chunk_if.playback_busy  <= req.playback_busy;
        do
            @(posedge clk);
        while (!chunk_if.ready);
        sent_count++;
    endtask

    // Stop offering and let every outstanding result come back
    task automatic drain_requests();
        chunk_if.valid <= 1'b0;
        while (reports_seen != sent_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        store_register(idx, val);
    endtask

    task automatic apply_settings(cfg_t c);
        drain_requests();
        // an index past the last register must be dropped
        write_register(CFG_IDX_W'(REG_BUFFER_BYTES + 1 + $urandom_range(2)),
                       CFG_DATA_W'($urandom));
        // junk in the upper bits of the 16-bit registers
        write_register(REG_SILENCE_LIMIT, {3'($urandom_range(7)), c.silence_limit_ms});
        write_register(REG_MAX_RECORD, {3'($urandom_range(7)), c.max_record_ms});
        write_register(REG_MIN_SPEECH, {3'($urandom_range(7)), c.min_speech_ms});
        write_register(REG_WAIT_SPEECH, {3'($urandom_range(7)), c.wait_for_speech_ms});
        write_register(REG_BUFFER_BYTES, c.buffer_bytes);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Predict each accepted request
    always @(posedge clk)
    begin : take_request
        item_t          req;
        pinned_result_t pin;
        result_t        guess;
        bit             idle_chunk;
        if (rst_n && chunk_if.valid && chunk_if.ready)
        begin
            req = '{chunk_if.cmd, chunk_if.wake_detected, chunk_if.speech_present,
                    chunk_if.chunk_bytes, chunk_if.playback_busy};
            pin = pinned_results.pop_front();
            guess = advance_endpointer(req, idle_chunk);
            if (!idle_chunk)
                worked_items++;
            endpoint_reports.push_back(pin.fixed ? pin.value : guess);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : take_result
        result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (endpoint_reports.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = endpoint_reports.pop_front();
                check_field("mode", want.mode, result_if.mode);
                check_field("captured_bytes", want.captured_bytes, result_if.captured_bytes);
                check_field("recorded_ms", want.recorded_ms, result_if.recorded_ms);
                check_field("end_reason", want.end_reason, result_if.end_reason);
                check_field("face_request", want.face_request, result_if.face_request);
                check_field("wake_event", want.wake_event, result_if.wake_event);
            end
            reports_seen++;
        end
    end

    // Result side: stall in blocks, block two and randomly chosen others calm, plus one long hold-off on request
    initial
    begin : result_sink
        int block_left;
        int block_no;
        int stall_pct;
        int hold_left;
        block_left = 0;
        block_no   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (block_left == 0)
            begin
                block_no++;
                block_left = 300;
                stall_pct = (block_no == 2 || $urandom_range(3) == 0) ? 0 : IDLE_PCT;
            end
            block_left--;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Give up when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chunk_if.valid && chunk_if.ready) || (result_if.valid && result_if.ready) ||
                cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t  picked;
        item_t req;
        int    gap_pct;
        int    roll;

        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        chunk_if.valid          <= 1'b0;
        chunk_if.cmd            <= CMD_CHUNK;
        chunk_if.wake_detected  <= 1'b0;
        chunk_if.speech_present <= 1'b0;
        chunk_if.chunk_bytes    <= '0;
        chunk_if.playback_busy  <= 1'b0;

        // model at reset
        ep_mode      = MODE_LISTEN;
        ep_suspended = 1'b0;
        clear_window();
        ep_limits = '{RST_SILENCE_LIMIT, RST_MAX_RECORD, RST_MIN_SPEECH, RST_WAIT_SPEECH,
                      RST_BUFFER_BYTES};

        // Directed walk; register defaults first
        plan_request('{CMD_CHUNK, 1'b0, 1'b0, 12'd0, 1'b0}, 1'b1,
                     '{MODE_LISTEN, 19'd0, 16'd0, REASON_NONE, FACE_NONE, 1'b0});
        plan_request('{CMD_CHUNK, 1'b1, 1'b1, 12'd4095, 1'b0}, 1'b1,
                     '{MODE_REC, 19'd0, 16'd0, REASON_NONE, FACE_REC, 1'b1});
        plan_request('{CMD_PAUSE, 1'b1, 1'b1, 12'd4095, 1'b1}, 1'b1,
                     '{MODE_LENT, 19'd0, 16'd0, REASON_NONE, FACE_NONE, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        plan_request('{CMD_RESUME, 1'b1, 1'b0, 12'd100, 1'b0}, 1'b1,
                     '{MODE_LISTEN, 19'd0, 16'd0, REASON_NONE, FACE_NONE, 1'b0});
        plan_request('{CMD_CHUNK, 1'b1, 1'b0, 12'd640, 1'b1});
        plan_request('{CMD_CHUNK, 1'b1, 1'b0, 12'd4095, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd2048, 1'b1});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        // short utterance that ends on silence, huge buffer
        plan_settings('{16'd100, 16'hFFFF, 16'd100, 16'hFFFF, 19'h7FFFF});
        plan_request('{CMD_FOLLOW, 1'b0, 1'b1, 12'd4095, 1'b1}, 1'b1,
                     '{MODE_REC, 19'd0, 16'd0, REASON_NONE, FACE_NONE, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b0, 12'd4095, 1'b0});
        plan_request('{CMD_CHUNK, 1'b1, 1'b1, 12'd4095, 1'b0});
        // silence and cap on the same chunk: cap wins
        plan_settings('{16'd0, 16'd100, 16'd0, 16'hFFFF, 19'd5000});
        plan_request('{CMD_FOLLOW, 1'b0, 1'b0, 12'd0, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        // second chunk overflows the buffer, and the cap hits on that same chunk
        plan_settings('{16'hFFFF, 16'd200, 16'd0, 16'hFFFF, 19'd5000});
        plan_request('{CMD_FOLLOW, 1'b0, 1'b0, 12'd0, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b1, 12'd4095, 1'b0});
        // nothing said beats the cap and the recording face
        plan_settings('{16'd0, 16'd100, 16'hFFFF, 16'd100, 19'd0});
        plan_request('{CMD_RESUME, 1'b0, 1'b0, 12'd0, 1'b0});
        plan_request('{CMD_CHUNK, 1'b1, 1'b0, 12'd4095, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b0, 12'd4095, 1'b1});
        plan_request('{CMD_CHUNK, 1'b0, 1'b0, 12'd4095, 1'b0}, 1'b1,
                     '{MODE_LISTEN, 19'd0, 16'd127, REASON_NOTHING, FACE_STANDBY, 1'b0});
        plan_request('{CMD_CHUNK, 1'b1, 1'b0, 12'd31, 1'b0});
        plan_request('{CMD_CHUNK, 1'b0, 1'b0, 12'd0, 1'b0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (test_plan[i])
        begin
            if (test_plan[i].is_cfg)
                apply_settings(test_plan[i].limits);
            else
                offer_request(test_plan[i].req, IDLE_PCT, test_plan[i].pin.fixed,
                              test_plan[i].pin.value);
        end

        // Saturate the counters with one long utterance that ends on the cap, under a long output hold-off
        apply_settings('{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 19'h7FFFF});
        hold_request = 1'b1;
        offer_request('{CMD_FOLLOW, 1'b0, 1'b0, 12'd0, 1'b0}, 0);
        repeat (SATURATE_CHUNKS)
        begin
            req = '{CMD_CHUNK, 1'($urandom_range(1)), 1'b1,
                    CHUNK_W'($urandom_range(4095, 3968)), 1'b0};
            offer_request(req, 0);
        end

        // Random phases, each under its own register setting
        while (worked_items < WORK_TARGET)
        begin
            picked.silence_limit_ms   = pick_ms(50, 1500);
            picked.max_record_ms      = pick_ms(200, 4000);
            picked.min_speech_ms      = pick_ms(0, 800);
            picked.wait_for_speech_ms = pick_ms(100, 3000);
            case ($urandom_range(5))
                0:       picked.buffer_bytes = '0;
                1:       picked.buffer_bytes = '1;
                default: picked.buffer_bytes = BYTES_W'($urandom_range(60000, 2000));
            endcase
            apply_settings(picked);
            gap_pct = ($urandom_range(4) == 0) ? 0 : IDLE_PCT;
            repeat ($urandom_range(120, 40))
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    req.cmd = CMD_FOLLOW;
                else if (roll < 7)
                    req.cmd = CMD_PAUSE;
                else if (roll < 11)
                    req.cmd = CMD_RESUME;
                else
                    req.cmd = CMD_CHUNK;
                req.wake_detected  = $urandom_range(99) < 20;
                req.speech_present = $urandom_range(99) < 55;
                req.playback_busy  = $urandom_range(99) < 7;
                case ($urandom_range(9))
                    0:       req.chunk_bytes = '0;
                    1:       req.chunk_bytes = '1;
                    2:       req.chunk_bytes = CHUNK_W'($urandom_range(31));
                    default: req.chunk_bytes = CHUNK_W'($urandom_range(4095));
                endcase
                offer_request(req, gap_pct);
            end
        end

        drain_requests();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
